// ===== rtl/gqv_pkg.sv =====
package gqv_pkg;

   // Table and grid sizes.
   localparam int GLYPH_ENTRIES = 256;
   localparam int GLYPH_AW = $clog2(GLYPH_ENTRIES);
   localparam int GRID_CELLS = 16;
   localparam logic [16:0] CELL_UV = 17'(65536 / GRID_CELLS);

   // Character codes with a meaning of their own.
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] FALLBACK_CODE = 8'd63;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

   // Request codes.
   localparam logic [1:0] REQ_GLYPH = 2'd0;
   localparam logic [1:0] REQ_CHAR = 2'd1;
   localparam logic [1:0] REQ_BEGIN = 2'd2;

   // Configuration register indexes.
   localparam logic [2:0] CFG_GLYPH_COUNT = 3'd0;
   localparam logic [2:0] CFG_FONT_SIZE = 3'd1;
   localparam logic [2:0] CFG_ORIGIN_X = 3'd2;
   localparam logic [2:0] CFG_ORIGIN_Y = 3'd3;
   localparam logic [2:0] CFG_VERTEX_COLOR = 3'd4;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] code;
      logic [16:0] glyph_u;
      logic [16:0] glyph_v;
      logic [16:0] glyph_u_end;
      logic [16:0] glyph_v_end;
      logic [15:0] glyph_width;
      logic [15:0] glyph_height;
      logic signed [15:0] glyph_x_offset;
      logic signed [15:0] glyph_y_offset;
      logic [15:0] glyph_advance;
   } gqv_req_type;

   typedef struct packed {
      logic signed [23:0] pos_x;
      logic signed [23:0] pos_y;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [31:0] color_rgba;
      logic last_vertex;
   } gqv_rsp_type;

   typedef struct packed {
      logic [8:0] glyph_count;
      logic [15:0] font_size;
      logic [23:0] origin_x;
      logic [23:0] origin_y;
      logic [31:0] vertex_color;
   } gqv_cfg_type;

   // One character's quad as it waits for the back.
   typedef struct packed {
      logic [23:0] x0;
      logic [23:0] y0;
      logic [17:0] w;
      logic [17:0] h;
      logic [16:0] u;
      logic [16:0] v;
      logic [16:0] u2;
      logic [16:0] v2;
   } gqv_quad_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic not_empty;
   } gqv_qstat_type;

endpackage

// ===== rtl/gqv_front.sv =====
module gqv_front
   import gqv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  gqv_req_type req_payload,
   input  gqv_cfg_type cfg,
   input  gqv_qstat_type qstat,
   output logic push_valid,
   output gqv_quad_type push_quad
);

   typedef enum logic [3:0] {
      OP_NONE = 4'b0001,
      OP_CHAR = 4'b0010,
      OP_NEWLINE = 4'b0100,
      OP_BEGIN = 4'b1000
   } op_type;

   typedef struct packed {
      logic [16:0] u;
      logic [16:0] u2;
      logic [16:0] v;
      logic [16:0] v2;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] advance;
      logic signed [15:0] x_off;
      logic signed [15:0] y_off;
   } glyph_entry_type;

   // Grid advance: floor(size * 3 / 5) as size * ceil(3 * 2^20 / 5) >> 20.
   localparam logic [19:0] ADV_RECIP = 20'd629146;
   localparam logic [8:0] GLYPH_LIMIT = 9'(GLYPH_ENTRIES);

   glyph_entry_type glyph_mem [GLYPH_ENTRIES];
   glyph_entry_type rd_ff;
   glyph_entry_type wr_entry;

   logic accept;
   logic table_mode;
   logic [8:0] cnt_eff;
   logic code_hit;
   logic fallback_hit;
   logic [7:0] eff_code;
   op_type op_in;

   op_type s1_op_ff;
   logic s1_table_ff;
   logic [7:0] s1_code_ff;

   op_type s2_op_ff;
   logic s2_table_ff;
   logic [31:0] s2_prod_w_ff;
   logic [31:0] s2_prod_h_ff;
   logic [31:0] s2_prod_adv_ff;
   logic signed [32:0] s2_prod_xo_ff;
   logic signed [32:0] s2_prod_yo_ff;
   logic [35:0] s2_grid_adv_ff;
   logic [16:0] s2_u_ff;
   logic [16:0] s2_v_ff;
   logic [16:0] s2_u2_ff;
   logic [16:0] s2_v2_ff;

   logic [31:0] prod_w_in;
   logic [31:0] prod_h_in;
   logic [31:0] prod_adv_in;
   logic signed [32:0] prod_xo_in;
   logic signed [32:0] prod_yo_in;
   logic [35:0] grid_adv_in;
   logic [16:0] grid_u;
   logic [16:0] grid_v;

   logic [17:0] w_sel;
   logic [17:0] h_sel;
   logic [17:0] adv_sel;
   logic [23:0] xo_sel;
   logic [23:0] yo_sel;

   logic [23:0] pen_x_ff;
   logic [23:0] pen_x_in;
   logic [23:0] pen_y_ff;
   logic [23:0] pen_y_in;

   logic [LEVEL_W+1:0] in_flight;

   // Credit check: every character in flight has a queue slot reserved.
   always_comb begin
      in_flight = (LEVEL_W+2)'(qstat.level)
                + (LEVEL_W+2)'(s1_op_ff == OP_CHAR)
                + (LEVEL_W+2)'(s2_op_ff == OP_CHAR);
      req_ready = in_flight < (LEVEL_W+2)'(QUEUE_DEPTH);
   end

   assign accept = req_valid && req_ready;

   // Classify the item and resolve a missing glyph to the fallback code.
   always_comb begin
      table_mode = |cfg.glyph_count;
      cnt_eff = (cfg.glyph_count > GLYPH_LIMIT) ? GLYPH_LIMIT : cfg.glyph_count;
      code_hit = {1'b0, req_payload.code} < cnt_eff;
      fallback_hit = {1'b0, FALLBACK_CODE} < cnt_eff;
      eff_code = code_hit ? req_payload.code : FALLBACK_CODE;
      op_in = OP_NONE;
      if (req_payload.req_type == REQ_CHAR) begin
         if (req_payload.code == NEWLINE_CODE) begin
            op_in = OP_NEWLINE;
         end else if (!table_mode || code_hit || fallback_hit) begin
            op_in = OP_CHAR;
         end
      end else if (req_payload.req_type == REQ_BEGIN) begin
         op_in = OP_BEGIN;
      end
   end

   always_comb begin
      wr_entry.u = req_payload.glyph_u;
      wr_entry.u2 = req_payload.glyph_u_end;
      wr_entry.v = req_payload.glyph_v;
      wr_entry.v2 = req_payload.glyph_v_end;
      wr_entry.width = req_payload.glyph_width;
      wr_entry.height = req_payload.glyph_height;
      wr_entry.advance = req_payload.glyph_advance;
      wr_entry.x_off = req_payload.glyph_x_offset;
      wr_entry.y_off = req_payload.glyph_y_offset;
   end

   // Glyph table: written by glyph items, read with a registered output.
   always_ff @(posedge clock) begin
      if (accept && req_payload.req_type == REQ_GLYPH &&
          {1'b0, req_payload.code} < GLYPH_LIMIT) begin
         glyph_mem[req_payload.code[GLYPH_AW-1:0]] <= wr_entry;
      end
      rd_ff <= glyph_mem[eff_code[GLYPH_AW-1:0]];
   end

   // Stage one registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_op_ff <= OP_NONE;
      end else begin
         s1_op_ff <= accept ? op_in : OP_NONE;
      end
      s1_table_ff <= table_mode;
      s1_code_ff <= req_payload.code;
   end

   // Stage one: scale the metrics by the font size.
   always_comb begin
      prod_w_in = {16'd0, rd_ff.width} * {16'd0, cfg.font_size};
      prod_h_in = {16'd0, rd_ff.height} * {16'd0, cfg.font_size};
      prod_adv_in = {16'd0, rd_ff.advance} * {16'd0, cfg.font_size};
      prod_xo_in = 33'(rd_ff.x_off) * signed'({17'd0, cfg.font_size});
      prod_yo_in = 33'(rd_ff.y_off) * signed'({17'd0, cfg.font_size});
      grid_adv_in = {20'd0, cfg.font_size} * {16'd0, ADV_RECIP};
      grid_u = {1'b0, s1_code_ff[3:0], 12'd0};
      grid_v = {1'b0, s1_code_ff[7:4], 12'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_op_ff <= OP_NONE;
      end else begin
         s2_op_ff <= s1_op_ff;
      end
      s2_table_ff <= s1_table_ff;
      s2_prod_w_ff <= prod_w_in;
      s2_prod_h_ff <= prod_h_in;
      s2_prod_adv_ff <= prod_adv_in;
      s2_prod_xo_ff <= prod_xo_in;
      s2_prod_yo_ff <= prod_yo_in;
      s2_grid_adv_ff <= grid_adv_in;
      s2_u_ff <= s1_table_ff ? rd_ff.u : grid_u;
      s2_v_ff <= s1_table_ff ? rd_ff.v : grid_v;
      s2_u2_ff <= s1_table_ff ? rd_ff.u2 : grid_u + CELL_UV;
      s2_v2_ff <= s1_table_ff ? rd_ff.v2 : grid_v + CELL_UV;
   end

   // Stage two: pick the metrics, place the quad and move the pen.
   always_comb begin
      if (s2_table_ff) begin
         w_sel = s2_prod_w_ff[31:14];
         h_sel = s2_prod_h_ff[31:14];
         adv_sel = s2_prod_adv_ff[31:14];
         xo_sel = {{5{s2_prod_xo_ff[32]}}, s2_prod_xo_ff[32:14]};
         yo_sel = {{5{s2_prod_yo_ff[32]}}, s2_prod_yo_ff[32:14]};
      end else begin
         w_sel = {2'd0, cfg.font_size};
         h_sel = {2'd0, cfg.font_size};
         adv_sel = {2'd0, s2_grid_adv_ff[35:20]};
         xo_sel = 24'd0;
         yo_sel = 24'd0;
      end
      push_quad.x0 = pen_x_ff + xo_sel;
      push_quad.y0 = pen_y_ff + yo_sel;
      push_quad.w = w_sel;
      push_quad.h = h_sel;
      push_quad.u = s2_u_ff;
      push_quad.v = s2_v_ff;
      push_quad.u2 = s2_u2_ff;
      push_quad.v2 = s2_v2_ff;
      push_valid = s2_op_ff == OP_CHAR;

      pen_x_in = pen_x_ff;
      pen_y_in = pen_y_ff;
      unique case (s2_op_ff)
         OP_CHAR: begin
            pen_x_in = pen_x_ff + {6'd0, adv_sel};
         end
         OP_NEWLINE: begin
            pen_x_in = cfg.origin_x;
            pen_y_in = pen_y_ff + {8'd0, cfg.font_size};
         end
         OP_BEGIN: begin
            pen_x_in = cfg.origin_x;
            pen_y_in = cfg.origin_y;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff <= 24'd0;
         pen_y_ff <= 24'd0;
      end else begin
         pen_x_ff <= pen_x_in;
         pen_y_ff <= pen_y_in;
      end
   end

endmodule

// ===== rtl/gqv_queue.sv =====
module gqv_queue
   import gqv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   input  gqv_quad_type push_quad,
   input  logic pop,
   output gqv_quad_type head_quad,
   output gqv_qstat_type qstat
);

   gqv_quad_type slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff;
   logic [QUEUE_AW-1:0] rd_ptr_ff;
   logic [LEVEL_W-1:0] level_ff;
   logic [LEVEL_W-1:0] level_in;
   logic do_pop;

   assign do_pop = pop && (level_ff != '0);
   assign head_quad = slot_ff[rd_ptr_ff];
   assign qstat.level = level_ff;
   assign qstat.not_empty = level_ff != '0;

   // Level tracks pushes and pops; the front never pushes into a full queue.
   always_comb begin
      level_in = level_ff;
      if (push_valid && !do_pop) begin
         level_in = level_ff + LEVEL_W'(1);
      end else if (!push_valid && do_pop) begin
         level_in = level_ff - LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_quad;
      end
   end

endmodule

// ===== rtl/gqv_back.sv =====
module gqv_back
   import gqv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  gqv_quad_type head_quad,
   input  gqv_qstat_type qstat,
   output logic pop,
   input  logic [31:0] vertex_color,
   output logic rsp_valid,
   input  logic rsp_ready,
   output gqv_rsp_type rsp_payload
);

   // Corner order of the two triangles: TL, TR, BL, BL, TR, BR.
   localparam logic [2:0] CORNER_TL = 3'd0;
   localparam logic [2:0] CORNER_TR_A = 3'd1;
   localparam logic [2:0] CORNER_BL_A = 3'd2;
   localparam logic [2:0] CORNER_BL_B = 3'd3;
   localparam logic [2:0] CORNER_TR_B = 3'd4;
   localparam logic [2:0] CORNER_BR = 3'd5;

   logic quad_valid_ff;
   logic [2:0] corner_ff;
   logic [23:0] x0_ff;
   logic [23:0] y0_ff;
   logic [23:0] x1_ff;
   logic [23:0] y1_ff;
   logic [16:0] u_ff;
   logic [16:0] v_ff;
   logic [16:0] u2_ff;
   logic [16:0] v2_ff;

   logic rsp_valid_ff;
   gqv_rsp_type rsp_ff;
   gqv_rsp_type rsp_in;

   logic emit;
   logic quad_done;
   logic sel_x1;
   logic sel_y1;

   assign emit = quad_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign quad_done = emit && (corner_ff == CORNER_BR);
   assign pop = qstat.not_empty && (!quad_valid_ff || quad_done);

   // Build the vertex for the current corner.
   always_comb begin
      sel_x1 = corner_ff inside {CORNER_TR_A, CORNER_TR_B, CORNER_BR};
      sel_y1 = corner_ff inside {CORNER_BL_A, CORNER_BL_B, CORNER_BR};
      rsp_in.pos_x = sel_x1 ? x1_ff : x0_ff;
      rsp_in.pos_y = sel_y1 ? y1_ff : y0_ff;
      rsp_in.tex_u = sel_x1 ? u2_ff : u_ff;
      rsp_in.tex_v = sel_y1 ? v2_ff : v_ff;
      rsp_in.color_rgba = vertex_color;
      rsp_in.last_vertex = corner_ff == CORNER_BR;
   end

   // Quad holder and corner counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         quad_valid_ff <= 1'b0;
         corner_ff <= CORNER_TL;
      end else begin
         if (pop) begin
            quad_valid_ff <= 1'b1;
            corner_ff <= CORNER_TL;
         end else if (quad_done) begin
            quad_valid_ff <= 1'b0;
            corner_ff <= CORNER_TL;
         end else if (emit) begin
            corner_ff <= corner_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         x0_ff <= head_quad.x0;
         y0_ff <= head_quad.y0;
         x1_ff <= head_quad.x0 + {6'd0, head_quad.w};
         y1_ff <= head_quad.y0 + {6'd0, head_quad.h};
         u_ff <= head_quad.u;
         v_ff <= head_quad.v;
         u2_ff <= head_quad.u2;
         v2_ff <= head_quad.v2;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/glyph_quad_vertex_generator.sv =====
// The first vertex of a character passes the stage one and stage two registers, the queue
// slot, the quad holder and the output register. Throughput: one vertex per cycle while
// rsp_ready is high, and a single output port carries all six corners of each character.
// Reset is synchronous and active high: it clears the pen, the queue and the handshakes
// and loads the registers with their reset values; the glyph table is left as it is.
module glyph_quad_vertex_generator
   import gqv_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  gqv_req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output gqv_rsp_type rsp_payload,
   input  logic csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [31:0] csr_wdata
);

   gqv_cfg_type cfg_ff;
   gqv_qstat_type qstat;
   gqv_quad_type push_quad;
   gqv_quad_type head_quad;
   logic push_valid;
   logic pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_count <= 9'd0;
         cfg_ff.font_size <= 16'd4096;
         cfg_ff.origin_x <= 24'd0;
         cfg_ff.origin_y <= 24'd0;
         cfg_ff.vertex_color <= 32'hFFFF_FFFF;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CFG_GLYPH_COUNT: cfg_ff.glyph_count <= csr_wdata[8:0];
            CFG_FONT_SIZE: cfg_ff.font_size <= csr_wdata[15:0];
            CFG_ORIGIN_X: cfg_ff.origin_x <= csr_wdata[23:0];
            CFG_ORIGIN_Y: cfg_ff.origin_y <= csr_wdata[23:0];
            CFG_VERTEX_COLOR: cfg_ff.vertex_color <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   gqv_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .cfg(cfg_ff),
      .qstat(qstat),
      .push_valid(push_valid),
      .push_quad(push_quad)
   );

   gqv_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_quad(push_quad),
      .pop(pop),
      .head_quad(head_quad),
      .qstat(qstat)
   );

   gqv_back u_back (
      .clock(clock),
      .reset(reset),
      .head_quad(head_quad),
      .qstat(qstat),
      .pop(pop),
      .vertex_color(cfg_ff.vertex_color),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
